// File: rtl/sot2d_pkg.sv
// Shared types and constants for the 2D shape overlap tester.
// No dependencies; the stage modules and the top level use these by scoped name.

package sot2d_pkg;

	// Operation codes on the func field; other codes give no hit
	typedef enum logic [2:0] {
		FUNC_BOX_BOX       = 3'd0,
		FUNC_BOX_POINT     = 3'd1,
		FUNC_BOX_CIRCLE    = 3'd2,
		FUNC_CIRCLE_CIRCLE = 3'd3,
		FUNC_CIRCLE_POINT  = 3'd4
	} func_t;

	localparam int FUNC_BITS   = 3;
	localparam int NUM_CORNERS = 4;
	localparam int NUM_MAGS    = 4;

	// Slots of the axis distance vector: source box edge against dest center
	localparam int MAG_X0 = 0;
	localparam int MAG_X1 = 1;
	localparam int MAG_Y0 = 2;
	localparam int MAG_Y1 = 3;

	// Corner slots: (x0,y0) also serves the circle-circle and circle-point tests
	localparam int CORNER_X0Y0 = 0;
	localparam int CORNER_X1Y1 = 1;
	localparam int CORNER_X0Y1 = 2;
	localparam int CORNER_X1Y0 = 3;

	// Per-item control that rides the pipeline
	typedef struct packed {
		logic                   direct;       // hit decided by compares alone
		logic [NUM_CORNERS-1:0] corner_mask;  // corners whose distance test counts
	} ctl_t;

endpackage

// File: rtl/sot2d_in_if.sv
// Input channel of the overlap tester: valid/ready plus one shape pair.
// Depends on nothing but the COORD_BITS parameter.

interface sot2d_in_if #(
	parameter int COORD_BITS = 24
);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   func;
	logic signed [COORD_BITS-1:0] src_x0;
	logic signed [COORD_BITS-1:0] src_y0;
	logic signed [COORD_BITS-1:0] src_x1;
	logic signed [COORD_BITS-1:0] src_y1;
	logic [COORD_BITS-2:0]        src_radius;
	logic signed [COORD_BITS-1:0] dst_x0;
	logic signed [COORD_BITS-1:0] dst_y0;
	logic signed [COORD_BITS-1:0] dst_x1;
	logic signed [COORD_BITS-1:0] dst_y1;
	logic [COORD_BITS-2:0]        dst_radius;

	modport source (
		output valid, func, src_x0, src_y0, src_x1, src_y1, src_radius,
		output dst_x0, dst_y0, dst_x1, dst_y1, dst_radius,
		input  ready
	);
	modport sink (
		input  valid, func, src_x0, src_y0, src_x1, src_y1, src_radius,
		input  dst_x0, dst_y0, dst_x1, dst_y1, dst_radius,
		output ready
	);
endinterface

// File: rtl/sot2d_out_if.sv
// Result channel of the overlap tester: valid/ready plus the hit flag.
// No dependencies.

interface sot2d_out_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (
		output valid, hit,
		input  ready
	);
	modport sink (
		input  valid, hit,
		output ready
	);
endinterface

// File: rtl/sot2d_prep.sv
// Stage 1: box compares, axis distances and radius select.
// Depends on sot2d_pkg.

module sot2d_prep #(
	parameter int COORD_BITS = 24
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  logic                                        in_valid,
	input  logic [sot2d_pkg::FUNC_BITS-1:0]             func,
	input  logic signed [COORD_BITS-1:0]                src_x0,
	input  logic signed [COORD_BITS-1:0]                src_y0,
	input  logic signed [COORD_BITS-1:0]                src_x1,
	input  logic signed [COORD_BITS-1:0]                src_y1,
	input  logic [COORD_BITS-2:0]                       src_radius,
	input  logic signed [COORD_BITS-1:0]                dst_x0,
	input  logic signed [COORD_BITS-1:0]                dst_y0,
	input  logic signed [COORD_BITS-1:0]                dst_x1,
	input  logic signed [COORD_BITS-1:0]                dst_y1,
	input  logic [COORD_BITS-2:0]                       dst_radius,
	output logic                                        valid_s1,
	output sot2d_pkg::ctl_t                             ctl_s1,
	output logic [sot2d_pkg::NUM_MAGS-1:0][COORD_BITS-1:0] mag_s1,
	output logic [COORD_BITS-1:0]                       rad_s1
);
	localparam int W = COORD_BITS;

	// One extra bit keeps differences and grown bounds exact
	logic signed [W:0] sx0, sy0, sx1, sy1, cx, cy, dx1e, dy1e, dre;
	logic signed [W:0] diff [sot2d_pkg::NUM_MAGS];
	logic [sot2d_pkg::NUM_MAGS-1:0][W-1:0] mag;
	logic signed [W:0] gx0, gy0, gx1, gy1;
	logic box_box, box_point, slab, grown;
	logic [W-1:0] rad;
	sot2d_pkg::ctl_t ctl;

	assign sx0  = {src_x0[W-1], src_x0};
	assign sy0  = {src_y0[W-1], src_y0};
	assign sx1  = {src_x1[W-1], src_x1};
	assign sy1  = {src_y1[W-1], src_y1};
	assign cx   = {dst_x0[W-1], dst_x0};
	assign cy   = {dst_y0[W-1], dst_y0};
	assign dx1e = {dst_x1[W-1], dst_x1};
	assign dy1e = {dst_y1[W-1], dst_y1};
	assign dre  = {2'b00, dst_radius};

	// Source box edges against the dest center, as magnitudes
	assign diff[sot2d_pkg::MAG_X0] = sx0 - cx;
	assign diff[sot2d_pkg::MAG_X1] = sx1 - cx;
	assign diff[sot2d_pkg::MAG_Y0] = sy0 - cy;
	assign diff[sot2d_pkg::MAG_Y1] = sy1 - cy;

	always_comb begin
		logic signed [W:0] neg;
		for (int i = 0; i < sot2d_pkg::NUM_MAGS; i++) begin
			neg    = -diff[i];
			mag[i] = diff[i][W] ? neg[W-1:0] : diff[i][W-1:0];
		end
	end

	// Box compares, inclusive bounds
	assign box_box   = !(sx0 > dx1e || sx1 < cx || sy0 > dy1e || sy1 < cy);
	assign box_point = sx0 <= cx && sx1 >= cx && sy0 <= cy && sy1 >= cy;
	assign slab      = (sx0 <= cx && sx1 >= cx) || (sy0 <= cy && sy1 >= cy);
	assign gx0       = sx0 - dre;
	assign gy0       = sy0 - dre;
	assign gx1       = sx1 + dre;
	assign gy1       = sy1 + dre;
	assign grown     = gx0 <= cx && gx1 >= cx && gy0 <= cy && gy1 >= cy;

	// Per-operation control and radius
	always_comb begin
		ctl.direct      = 1'b0;
		ctl.corner_mask = '0;
		rad             = '0;
		case (sot2d_pkg::func_t'(func))
			sot2d_pkg::FUNC_BOX_BOX: begin
				ctl.direct = box_box;
			end
			sot2d_pkg::FUNC_BOX_POINT: begin
				ctl.direct = box_point;
			end
			sot2d_pkg::FUNC_BOX_CIRCLE: begin
				rad = {1'b0, dst_radius};
				if (slab) begin
					ctl.direct = grown;
				end else begin
					ctl.corner_mask = '1;
				end
			end
			sot2d_pkg::FUNC_CIRCLE_CIRCLE: begin
				rad = {1'b0, src_radius} + {1'b0, dst_radius};
				ctl.corner_mask[sot2d_pkg::CORNER_X0Y0] = 1'b1;
			end
			sot2d_pkg::FUNC_CIRCLE_POINT: begin
				rad = {1'b0, src_radius};
				ctl.corner_mask[sot2d_pkg::CORNER_X0Y0] = 1'b1;
			end
			default: begin
				ctl.direct = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ctl_s1 <= ctl;
			mag_s1 <= mag;
			rad_s1 <= rad;
		end
	end

endmodule

// File: rtl/sot2d_square.sv
// Stage 2: squares of the four axis distances and of the radius.
// Depends on sot2d_pkg.

module sot2d_square #(
	parameter int COORD_BITS = 24
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           en,
	input  logic                                           valid_s1,
	input  sot2d_pkg::ctl_t                                ctl_s1,
	input  logic [sot2d_pkg::NUM_MAGS-1:0][COORD_BITS-1:0] mag_s1,
	input  logic [COORD_BITS-1:0]                          rad_s1,
	output logic                                           valid_s2,
	output sot2d_pkg::ctl_t                                ctl_s2,
	output logic [sot2d_pkg::NUM_MAGS-1:0][2*COORD_BITS-1:0] sq_s2,
	output logic [2*COORD_BITS-1:0]                        rsq_s2
);
	localparam int PW = 2 * COORD_BITS;

	logic [sot2d_pkg::NUM_MAGS-1:0][PW-1:0] sq;
	logic [PW-1:0] rsq;

	// Unsigned W x W products, one register after each
	always_comb begin
		for (int i = 0; i < sot2d_pkg::NUM_MAGS; i++) begin
			sq[i] = {{COORD_BITS{1'b0}}, mag_s1[i]} * {{COORD_BITS{1'b0}}, mag_s1[i]};
		end
	end

	assign rsq = {{COORD_BITS{1'b0}}, rad_s1} * {{COORD_BITS{1'b0}}, rad_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			ctl_s2 <= ctl_s1;
			sq_s2  <= sq;
			rsq_s2 <= rsq;
		end
	end

endmodule

// File: rtl/sot2d_judge.sv
// Stage 3: corner distance sums against the squared radius; output register.
// Depends on sot2d_pkg.

module sot2d_judge #(
	parameter int COORD_BITS = 24
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             en,
	input  logic                                             valid_s2,
	input  sot2d_pkg::ctl_t                                  ctl_s2,
	input  logic [sot2d_pkg::NUM_MAGS-1:0][2*COORD_BITS-1:0] sq_s2,
	input  logic [2*COORD_BITS-1:0]                          rsq_s2,
	output logic                                             valid_s3,
	output logic                                             hit_s3
);
	localparam int SW = 2 * COORD_BITS + 1;

	logic [SW-1:0] d2 [sot2d_pkg::NUM_CORNERS];
	logic [sot2d_pkg::NUM_CORNERS-1:0] near;
	logic hit;

	// Squared corner-to-center distance per corner
	assign d2[sot2d_pkg::CORNER_X0Y0] = {1'b0, sq_s2[sot2d_pkg::MAG_X0]}
		+ {1'b0, sq_s2[sot2d_pkg::MAG_Y0]};
	assign d2[sot2d_pkg::CORNER_X1Y1] = {1'b0, sq_s2[sot2d_pkg::MAG_X1]}
		+ {1'b0, sq_s2[sot2d_pkg::MAG_Y1]};
	assign d2[sot2d_pkg::CORNER_X0Y1] = {1'b0, sq_s2[sot2d_pkg::MAG_X0]}
		+ {1'b0, sq_s2[sot2d_pkg::MAG_Y1]};
	assign d2[sot2d_pkg::CORNER_X1Y0] = {1'b0, sq_s2[sot2d_pkg::MAG_X1]}
		+ {1'b0, sq_s2[sot2d_pkg::MAG_Y0]};

	always_comb begin
		for (int i = 0; i < sot2d_pkg::NUM_CORNERS; i++) begin
			near[i] = d2[i] <= {1'b0, rsq_s2};
		end
	end

	assign hit = ctl_s2.direct || |(ctl_s2.corner_mask & near);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			hit_s3 <= hit;
		end
	end

endmodule

// File: rtl/shape_overlap_test_2d_unit.sv
// Top level of the 2D shape overlap tester: three-stage pipeline.
// Depends on sot2d_pkg, sot2d_in_if, sot2d_out_if, sot2d_prep,
// sot2d_square and sot2d_judge.
//
//   channel  | modport | payload
//   ---------+---------+-------------------------------------------------
//   pair     | sink    | func, src_x0/y0/x1/y1/radius, dst_x0/y0/x1/y1/radius
//   result   | source  | hit
//
// One transfer in and one out per cycle while the result is taken.
// Stage 1 does the compares and distances, stage 2 the five squarers,
// stage 3 the corner sums and the output register.
// Reset clears the stage valid bits only; payload registers are not reset.
// Each stage takes a new item when it is empty or its successor moves,
// so bubbles close up and a stalled result holds without loss.

module shape_overlap_test_2d_unit #(
	parameter int COORD_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	sot2d_in_if.sink     pair,
	sot2d_out_if.source  result
);
	localparam int PW = 2 * COORD_BITS;

	logic rdy1, rdy2, rdy3;
	logic valid_s1, valid_s2, valid_s3;
	logic hit_s3;
	sot2d_pkg::ctl_t ctl_s1, ctl_s2;
	logic [sot2d_pkg::NUM_MAGS-1:0][COORD_BITS-1:0] mag_s1;
	logic [COORD_BITS-1:0] rad_s1;
	logic [sot2d_pkg::NUM_MAGS-1:0][PW-1:0] sq_s2;
	logic [PW-1:0] rsq_s2;

	// Per-stage advance: empty, or the next stage moves
	assign rdy3 = !valid_s3 || result.ready;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign pair.ready   = rdy1;
	assign result.valid = valid_s3;
	assign result.hit   = hit_s3;

	sot2d_prep #(
		.COORD_BITS (COORD_BITS)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (rdy1),
		.in_valid   (pair.valid),
		.func       (pair.func),
		.src_x0     (pair.src_x0),
		.src_y0     (pair.src_y0),
		.src_x1     (pair.src_x1),
		.src_y1     (pair.src_y1),
		.src_radius (pair.src_radius),
		.dst_x0     (pair.dst_x0),
		.dst_y0     (pair.dst_y0),
		.dst_x1     (pair.dst_x1),
		.dst_y1     (pair.dst_y1),
		.dst_radius (pair.dst_radius),
		.valid_s1   (valid_s1),
		.ctl_s1     (ctl_s1),
		.mag_s1     (mag_s1),
		.rad_s1     (rad_s1)
	);

	sot2d_square #(
		.COORD_BITS (COORD_BITS)
	) u_square (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (rdy2),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1),
		.mag_s1   (mag_s1),
		.rad_s1   (rad_s1),
		.valid_s2 (valid_s2),
		.ctl_s2   (ctl_s2),
		.sq_s2    (sq_s2),
		.rsq_s2   (rsq_s2)
	);

	sot2d_judge #(
		.COORD_BITS (COORD_BITS)
	) u_judge (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (rdy3),
		.valid_s2 (valid_s2),
		.ctl_s2   (ctl_s2),
		.sq_s2    (sq_s2),
		.rsq_s2   (rsq_s2),
		.valid_s3 (valid_s3),
		.hit_s3   (hit_s3)
	);

`ifndef ASSERT_OFF
	// Input backpressure only when every stage is full and the output stalls
	a_backpressure_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pair.ready |-> (valid_s1 && valid_s2 && valid_s3 && !result.ready))
		else $error("input stalled with room in the pipeline");

	// With the output ready while it passes, a transfer in reaches result.valid through the s1, s2 and s3 registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pair.valid && pair.ready) ##1 result.ready ##1 result.ready |=> result.valid)
		else $error("item lost or late in the pipeline");

	// Compare-decided items never also ask for a distance test
	a_ctl_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctl_s1.direct) |-> (ctl_s1.corner_mask == '0))
		else $error("direct hit and corner tests both set");
`endif

endmodule
